[hdl/ccg_pkg.sv]
// ccg_pkg: shared constants, types and helper functions for the candidate generator
// used by ccg_cell, ccg_chain and charset_candidate_generator; depends on nothing
package ccg_pkg;

    // longest candidate and field widths
    localparam int MaxLen = 16;
    localparam int DigitW = 6;
    localparam int LenW   = 5;
    localparam int PosW   = 4;
    localparam int CharW  = 7;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 6;

    // alphabet bounds and symbol bases
    localparam logic [DigitW-1:0] AlphaMax   = 6'd62;
    localparam logic [CharW-1:0]  CharLowerA = 7'h61;
    localparam logic [CharW-1:0]  CharUpperA = 7'h41;
    localparam logic [CharW-1:0]  CharZero   = 7'h30;
    localparam logic [CharW-1:0]  NumLetters = 7'd26;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] RegAlphabetSize = 2'd0;
    localparam logic [CfgIdxW-1:0] RegStartLength  = 2'd1;
    localparam logic [CfgIdxW-1:0] RegMaxLength    = 2'd2;

    // reset values of the configuration registers
    localparam logic [DigitW-1:0] RstAlphabetSize = 6'd62;
    localparam logic [LenW-1:0]   RstStartLength  = 5'd6;
    localparam logic [LenW-1:0]   RstMaxLength    = 5'd16;

    // per-cycle command to every cell of the digit chain
    typedef struct packed {
        logic clear;
        logic shift;
        logic incr;
    } ccg_cell_ctl_t;

    // length register values below 1 or above MaxLen are pinned to the range
    function automatic logic [LenW-1:0] clamp_len(input logic [LenW-1:0] v);
        logic [LenW-1:0] r;
        if (v == '0) begin
            r = LenW'(1);
        end else if (v > LenW'(MaxLen)) begin
            r = LenW'(MaxLen);
        end else begin
            r = v;
        end
        return r;
    endfunction

    // radix of every digit, 1..62
    function automatic logic [DigitW-1:0] eff_radix(input logic [DigitW-1:0] v);
        logic [DigitW-1:0] r;
        if (v == '0) begin
            r = DigitW'(1);
        end else if (v > AlphaMax) begin
            r = AlphaMax;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // digit to ascii: a-z, A-Z, 0-9, unused codes map to '0'
    function automatic logic [CharW-1:0] digit_to_char(input logic [DigitW-1:0] d);
        logic [CharW-1:0] dx;
        logic [CharW-1:0] c;
        dx = {1'b0, d};
        if (dx < NumLetters) begin
            c = CharLowerA + dx;
        end else if (dx < 7'(2 * NumLetters)) begin
            c = CharUpperA + dx - NumLetters;
        end else if (dx < 7'(AlphaMax)) begin
            c = CharZero + dx - 7'(2 * NumLetters);
        end else begin
            c = CharZero;
        end
        return c;
    endfunction

endpackage

[hdl/ccg_cell.sv]
// ccg_cell: one digit of the odometer, with shift and carry links to its neighbors
// depends on ccg_pkg
module ccg_cell import ccg_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ccg_cell_ctl_t        ctl,
    input  logic                 is_tail,
    input  logic [DigitW-1:0]    head_digit,
    input  logic [DigitW-1:0]    right_digit,
    input  logic                 right_carry,
    input  logic [DigitW-1:0]    radix,
    output logic [DigitW-1:0]    digit,
    output logic                 carry_out
);

    logic [DigitW-1:0] digit_reg;
    logic [DigitW-1:0] digit_next;
    logic [DigitW:0]   sum;
    logic              sat;
    logic              carry_in;

    // increment with carry; the tail cell starts the carry
    assign carry_in  = is_tail | right_carry;
    assign sum       = {1'b0, digit_reg} + (DigitW+1)'(1);
    assign sat       = (sum >= {1'b0, radix});
    assign carry_out = carry_in & sat;

    // next digit: clear, rotate toward the head, or count
    always_comb begin
        digit_next = digit_reg;
        if (ctl.clear) begin
            digit_next = '0;
        end else if (ctl.shift) begin
            digit_next = is_tail ? head_digit : right_digit;
        end else if (ctl.incr && carry_in) begin
            digit_next = sat ? '0 : sum[DigitW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_reg <= '0;
        end else begin
            digit_reg <= digit_next;
        end
    end

    assign digit = digit_reg;

endmodule

[hdl/ccg_chain.sv]
// ccg_chain: row of MaxLen digit cells forming a rotating ring and a carry chain
// depends on ccg_pkg and ccg_cell
module ccg_chain import ccg_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  ccg_cell_ctl_t      ctl,
    input  logic [LenW-1:0]    cur_len,
    input  logic [DigitW-1:0]  radix,
    output logic [DigitW-1:0]  head_digit,
    output logic               overflow
);

    logic [DigitW-1:0] digit_w [0:MaxLen];
    logic [MaxLen:0]   carry_w;
    logic [MaxLen-1:0] tail_sel;

    // nothing enters from the right of the last cell
    assign digit_w[MaxLen] = '0;
    assign carry_w[MaxLen] = 1'b0;

    // one-hot mark of the rightmost digit in use
    always_comb begin
        for (int k = 0; k < MaxLen; k++) begin
            tail_sel[k] = (cur_len == LenW'(k + 1));
        end
    end

    for (genvar k = 0; k < MaxLen; k++) begin : g_cell
        ccg_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (ctl),
            .is_tail     (tail_sel[k]),
            .head_digit  (digit_w[0]),
            .right_digit (digit_w[k+1]),
            .right_carry (carry_w[k+1]),
            .radix       (radix),
            .digit       (digit_w[k]),
            .carry_out   (carry_w[k])
        );
    end

    assign head_digit = digit_w[0];
    assign overflow   = carry_w[0];

endmodule

[hdl/charset_candidate_generator.sv]
// charset_candidate_generator: keyspace odometer emitting one candidate character per beat
// depends on ccg_pkg and ccg_chain
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------------
//  s_       | s_valid / s_ready      | s_restart
//  m_       | m_valid / m_ready      | m_character, m_char_position, m_cand_length,
//           |                        | m_last_char, m_wrapped
//  cfg_     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// a request is served in steps: the request is taken, then the digit ring rotates past its
// head cell once per character, then the odometer counts up through the cell carry chain.
// output stalls hold the ring; a new request is taken while the last beat still waits.
// synchronous active-low reset restores the register defaults and clears all digits.
module charset_candidate_generator import ccg_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_restart,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [CharW-1:0]     m_character,
    output logic [PosW-1:0]      m_char_position,
    output logic [LenW-1:0]      m_cand_length,
    output logic                 m_last_char,
    output logic                 m_wrapped,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CfgIdxW-1:0]   cfg_index,
    input  logic [CfgDataW-1:0]  cfg_data
);

    localparam logic [1:0] StIdle = 2'd0;
    localparam logic [1:0] StEmit = 2'd1;
    localparam logic [1:0] StAdv  = 2'd2;

    logic [1:0]         state_reg,  state_next;
    logic [DigitW-1:0]  alpha_reg;
    logic [LenW-1:0]    start_reg;
    logic [LenW-1:0]    max_reg;
    logic [LenW-1:0]    len_reg,    len_next;
    logic               wrap_reg,   wrap_next;
    logic               flag_reg,   flag_next;
    logic [PosW-1:0]    pos_reg,    pos_next;
    logic               m_valid_reg, m_valid_next;
    logic [CharW-1:0]   m_char_reg;
    logic [PosW-1:0]    m_pos_reg;
    logic [LenW-1:0]    m_len_reg;
    logic               m_last_reg;
    logic               m_wrap_reg;
    logic               load_beat;
    logic               is_last;
    logic               s_fire;
    ccg_cell_ctl_t      ctl;
    logic [DigitW-1:0]  head_digit;
    logic               overflow;
    logic [DigitW-1:0]  radix;

    assign radix     = eff_radix(alpha_reg);
    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == StIdle);
    assign s_fire    = s_valid & s_ready;
    assign is_last   = ({1'b0, pos_reg} == (len_reg - LenW'(1)));
    assign load_beat = (state_reg == StEmit) && (!m_valid_reg || m_ready);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg <= RstAlphabetSize;
            start_reg <= RstStartLength;
            max_reg   <= RstMaxLength;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                RegAlphabetSize: alpha_reg <= cfg_data;
                RegStartLength:  start_reg <= cfg_data[LenW-1:0];
                RegMaxLength:    max_reg   <= cfg_data[LenW-1:0];
                default: ;
            endcase
        end
    end

    // sequencer: take request, rotate out characters, count up
    always_comb begin
        state_next   = state_reg;
        len_next     = len_reg;
        wrap_next    = wrap_reg;
        flag_next    = flag_reg;
        pos_next     = pos_reg;
        m_valid_next = m_valid_reg;
        ctl          = '0;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            StIdle: begin
                if (s_fire) begin
                    pos_next   = '0;
                    wrap_next  = 1'b0;
                    state_next = StEmit;
                    if (s_restart) begin
                        ctl.clear = 1'b1;
                        len_next  = clamp_len(start_reg);
                        flag_next = 1'b0;
                    end else begin
                        flag_next = wrap_reg;
                    end
                end
            end
            StEmit: begin
                if (load_beat) begin
                    m_valid_next = 1'b1;
                    ctl.shift    = 1'b1;
                    pos_next     = pos_reg + PosW'(1);
                    if (is_last) begin
                        state_next = StAdv;
                    end
                end
            end
            StAdv: begin
                ctl.incr   = 1'b1;
                state_next = StIdle;
                if (overflow) begin
                    if (len_reg >= clamp_len(max_reg)) begin
                        len_next  = clamp_len(start_reg);
                        wrap_next = 1'b1;
                    end else begin
                        len_next = len_reg + LenW'(1);
                    end
                end
            end
            default: begin
                state_next = StIdle;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= StIdle;
            len_reg     <= clamp_len(RstStartLength);
            wrap_reg    <= 1'b0;
            flag_reg    <= 1'b0;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            wrap_reg    <= wrap_next;
            flag_reg    <= flag_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // output beat register, loaded from the head cell
    always_ff @(posedge aclk) begin
        if (load_beat) begin
            m_char_reg <= digit_to_char(head_digit);
            m_pos_reg  <= pos_reg;
            m_len_reg  <= len_reg;
            m_last_reg <= is_last;
            m_wrap_reg <= flag_reg;
        end
    end

    // digit ring
    ccg_chain u_chain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .cur_len    (len_reg),
        .radix      (radix),
        .head_digit (head_digit),
        .overflow   (overflow)
    );

    assign m_valid         = m_valid_reg;
    assign m_character     = m_char_reg;
    assign m_char_position = m_pos_reg;
    assign m_cand_length   = m_len_reg;
    assign m_last_char     = m_last_reg;
    assign m_wrapped       = m_wrap_reg;

endmodule
